### src/fm_quadrature_discriminator_unit_macros.svh
// assertion helpers for the checker of this block
`ifndef FM_QUADRATURE_DISCRIMINATOR_UNIT_MACROS_SVH
`define FM_QUADRATURE_DISCRIMINATOR_UNIT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define FMQD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define FMQD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fmqd_pkg.sv
package fmqd_pkg;

    // sample and angle formats
    localparam int SAMPLE_WIDTH = 16;
    localparam int PHASE_WIDTH  = 16;
    localparam int ANGLE_W      = 32;
    localparam int PROD_W       = 2 * SAMPLE_WIDTH;
    localparam int ACC_W        = PROD_W + 1;
    localparam int GUARD_SHIFT  = 58 - 2 * SAMPLE_WIDTH;
    localparam int CORDIC_W     = ACC_W + GUARD_SHIFT + 2;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] i_sample;
        logic signed [SAMPLE_WIDTH-1:0] q_sample;
        logic                           last_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [PHASE_WIDTH-1:0] phase_delta;
        logic                          last_out;
    } out_beat_t;

    // work handed from the front end to the back end
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] ci;
        logic signed [SAMPLE_WIDTH-1:0] cq;
        logic signed [SAMPLE_WIDTH-1:0] pi;
        logic signed [SAMPLE_WIDTH-1:0] pq;
        logic                           last;
        logic                           run_cordic;
    } cmd_t;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] a;
        begin
            case (idx)
                5'd0:    a = 32'h2000_0000;
                5'd1:    a = 32'h12E4_051E;
                5'd2:    a = 32'h09FB_385B;
                5'd3:    a = 32'h0511_11D4;
                5'd4:    a = 32'h028B_0D43;
                5'd5:    a = 32'h0145_D7E1;
                5'd6:    a = 32'h00A2_F61E;
                5'd7:    a = 32'h0051_7C55;
                5'd8:    a = 32'h0028_BE53;
                5'd9:    a = 32'h0014_5F2F;
                5'd10:   a = 32'h000A_2F98;
                5'd11:   a = 32'h0005_17CC;
                5'd12:   a = 32'h0002_8BE6;
                5'd13:   a = 32'h0001_45F3;
                5'd14:   a = 32'h0000_A2FA;
                5'd15:   a = 32'h0000_517D;
                5'd16:   a = 32'h0000_28BE;
                5'd17:   a = 32'h0000_145F;
                5'd18:   a = 32'h0000_0A30;
                5'd19:   a = 32'h0000_0518;
                5'd20:   a = 32'h0000_028C;
                5'd21:   a = 32'h0000_0146;
                5'd22:   a = 32'h0000_00A3;
                5'd23:   a = 32'h0000_0051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

### src/fmqd_fifo.sv
module fmqd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/fmqd_front.sv
module fmqd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fmqd_pkg::in_beat_t sample,
    output logic              full,
    output logic              cmd_push,
    output fmqd_pkg::cmd_t    cmd,
    input  logic              cmd_full
);

    logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] prev_i_reg, prev_i_next;
    logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] prev_q_reg, prev_q_next;
    logic                                     have_prev_reg, have_prev_next;
    logic                                     accept;
    logic                                     cur_nonzero;
    logic                                     prev_nonzero;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    // product is zero exactly when either sample is zero
    assign cur_nonzero  = (sample.i_sample != '0) || (sample.q_sample != '0);
    assign prev_nonzero = (prev_i_reg != '0) || (prev_q_reg != '0);

    always_comb
    begin
        cmd.ci         = sample.i_sample;
        cmd.cq         = sample.q_sample;
        cmd.pi         = prev_i_reg;
        cmd.pq         = prev_q_reg;
        cmd.last       = sample.last_in;
        cmd.run_cordic = have_prev_reg && cur_nonzero && prev_nonzero;
    end

    always_comb
    begin
        prev_i_next    = prev_i_reg;
        prev_q_next    = prev_q_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            prev_i_next    = sample.i_sample;
            prev_q_next    = sample.q_sample;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

### src/fmqd_back.sv
module fmqd_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fmqd_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output fmqd_pkg::out_beat_t res,
    output logic                res_push,
    input  logic                res_full
);

    localparam int SW     = fmqd_pkg::SAMPLE_WIDTH;
    localparam int PW     = fmqd_pkg::PHASE_WIDTH;
    localparam int AW     = fmqd_pkg::ANGLE_W;
    localparam int PRW    = fmqd_pkg::PROD_W;
    localparam int ACW    = fmqd_pkg::ACC_W;
    localparam int XW     = fmqd_pkg::CORDIC_W;
    localparam int GS     = fmqd_pkg::GUARD_SHIFT;
    localparam int IDX_W  = fmqd_pkg::ATAN_IDX_W;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_ROT  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] MUL_RE_A = 2'd0;
    localparam logic [1:0] MUL_RE_B = 2'd1;
    localparam logic [1:0] MUL_IM_A = 2'd2;
    localparam logic [1:0] MUL_IM_B = 2'd3;

    localparam logic [AW-1:0] HALF_LSB = AW'(1) << (AW - 1 - PW);
    localparam logic [AW-1:0] PI_ANGLE = AW'(1) << (AW - 1);

    logic [2:0]              state_reg, state_next;
    logic [1:0]              mul_reg, mul_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [SW-1:0]    ci_reg, ci_next;
    logic signed [SW-1:0]    cq_reg, cq_next;
    logic signed [SW-1:0]    pi_reg, pi_next;
    logic signed [SW-1:0]    pq_reg, pq_next;
    logic                    last_reg, last_next;
    logic                    run_reg, run_next;
    logic signed [ACW-1:0]   re_reg, re_next;
    logic signed [ACW-1:0]   im_reg, im_next;
    logic signed [XW-1:0]    x_reg, x_next;
    logic signed [XW-1:0]    y_reg, y_next;
    logic [AW-1:0]           z_reg, z_next;

    logic signed [SW-1:0]    mul_a;
    logic signed [SW-1:0]    mul_b;
    logic signed [PRW-1:0]   prod;
    logic signed [ACW-1:0]   prod_ext;
    logic signed [XW-1:0]    re_wide;
    logic signed [XW-1:0]    im_wide;
    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic                    y_pos;
    logic [AW-1:0]           step_angle;
    logic [AW-1:0]           rounded;

    // one shared multiplier walks through the four cross products
    assign mul_a    = (mul_reg == MUL_RE_A || mul_reg == MUL_IM_B) ? ci_reg : cq_reg;
    assign mul_b    = (mul_reg == MUL_RE_A || mul_reg == MUL_IM_A) ? pi_reg : pq_reg;
    assign prod     = mul_a * mul_b;
    assign prod_ext = ACW'(prod);

    assign re_wide = XW'(re_reg) <<< GS;
    assign im_wide = XW'(im_reg) <<< GS;

    // arithmetic shift rounds toward minus infinity
    assign xs         = x_reg >>> step_reg;
    assign ys         = y_reg >>> step_reg;
    assign y_pos      = !y_reg[XW-1] && (y_reg != '0);
    assign step_angle = fmqd_pkg::atan_angle(IDX_W'(step_reg));

    assign rounded = z_reg + HALF_LSB;

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_DONE) && !res_full;

    always_comb
    begin
        res.phase_delta = run_reg ? rounded[AW-1 -: PW] : '0;
        res.last_out    = last_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_next   = mul_reg;
        step_next  = step_reg;
        ci_next    = ci_reg;
        cq_next    = cq_reg;
        pi_next    = pi_reg;
        pq_next    = pq_reg;
        last_next  = last_reg;
        run_next   = run_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    ci_next    = cmd.ci;
                    cq_next    = cmd.cq;
                    pi_next    = cmd.pi;
                    pq_next    = cmd.pq;
                    last_next  = cmd.last;
                    run_next   = cmd.run_cordic;
                    mul_next   = MUL_RE_A;
                    state_next = cmd.run_cordic ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                case (mul_reg)
                    MUL_RE_A: re_next = prod_ext;
                    MUL_RE_B: re_next = re_reg + prod_ext;
                    MUL_IM_A: im_next = prod_ext;
                    default:  im_next = im_reg - prod_ext;
                endcase
                mul_next = mul_reg + 1'b1;
                if (mul_reg == MUL_IM_B)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // left half plane: rotate by pi first
                if (re_reg[ACW-1])
                begin
                    x_next = -re_wide;
                    y_next = -im_wide;
                    z_next = PI_ANGLE;
                end
                else
                begin
                    x_next = re_wide;
                    y_next = im_wide;
                    z_next = '0;
                end
                step_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (y_pos)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + step_angle;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - step_angle;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mul_reg   <= MUL_RE_A;
            step_reg  <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mul_reg   <= mul_next;
            step_reg  <= step_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg   <= ci_next;
        cq_reg   <= cq_next;
        pi_reg   <= pi_next;
        pq_reg   <= pq_next;
        last_reg <= last_next;
        re_reg   <= re_next;
        im_reg   <= im_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

endmodule

### src/fm_quadrature_discriminator_unit.sv
// FM quadrature discriminator: each accepted beat carries one complex baseband
// sample; the block multiplies it by the conjugate of the previous sample and
// returns the angle of that product as a 16-bit binary angle (-32768 is -pi,
// +pi wraps to -pi), computed by a vectoring CORDIC with a 32-bit angle
// accumulator and rounded to the output width. The first sample after reset,
// and any sample where the current or previous sample is zero, gives 0; the
// last mark is copied to the result. A front end takes beats, keeps the
// previous sample and decides whether the CORDIC is needed; a two-entry
// command queue feeds the back end, and a two-entry result queue holds
// finished beats, so input keeps flowing while results wait to be popped.
// The back end handles one beat at a time: a beat that needs the CORDIC is
// loaded, takes the four cross products on the shared 16x16 multiplier, is
// scaled and folded into the right half plane, goes through CORDIC_STEPS
// rotations, and is then rounded and written; a beat that gives 0 directly
// is loaded and then written. A busy back end or a full result queue delays
// the result. CORDIC_STEPS may range from 8 to 24.
module fm_quadrature_discriminator_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int CMD_DEPTH    = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  fmqd_pkg::in_beat_t  sample,
    output logic                empty,
    input  logic                pop,
    output fmqd_pkg::out_beat_t result
);

    localparam int CMD_W = $bits(fmqd_pkg::cmd_t);
    localparam int RES_W = $bits(fmqd_pkg::out_beat_t);

    // front end to command queue
    fmqd_pkg::cmd_t      front_cmd;
    logic                front_push;
    logic                cmd_full;

    // command queue to back end
    fmqd_pkg::cmd_t      back_cmd;
    logic                cmd_empty;
    logic                cmd_pop;

    // back end to result queue
    fmqd_pkg::out_beat_t back_res;
    logic                res_push;
    logic                res_full;

    fmqd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .cmd_push (front_push),
        .cmd      (front_cmd),
        .cmd_full (cmd_full)
    );

    fmqd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    fmqd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // finished beats wait here until popped
    fmqd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

### src/fmqd_checker.sv
`include "fm_quadrature_discriminator_unit_macros.svh"

module fmqd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input fmqd_pkg::out_beat_t result
);

    logic [7:0] outstanding_reg, outstanding_next;
    logic       seen_out_reg, seen_out_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        seen_out_next    = seen_out_reg || out_beat;
        if (in_beat && !out_beat)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            seen_out_reg    <= 1'b0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            seen_out_reg    <= seen_out_next;
        end
    end

    // no result without a sample still owed one
    `FMQD_ASSERT(a_no_invented_result, !empty |-> (outstanding_reg != '0), "result without pending sample")

    // with nothing in flight the block must take input
    `FMQD_ASSERT(a_idle_not_full, (outstanding_reg == '0) |-> !full, "full while idle")

    // very first result follows the first sample, which has no predecessor
    `FMQD_ASSERT(a_first_result_zero, (!empty && !seen_out_reg) |-> (result.phase_delta == '0), "first phase not zero")

    // a waiting result holds until popped
    `FMQD_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while stalled")

    // queue reads as empty on the edge after reset was seen
    `FMQD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result shown during reset")

endmodule

bind fm_quadrature_discriminator_unit fmqd_checker u_fmqd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
